>>> hw/rtl/ast_pkg.sv
// shared constants and types for the stutter repeat block
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths of a request
    localparam int LEN_BITS   = 13;
    localparam int COUNT_BITS = 8;
    localparam int INDEX_BITS = COUNT_BITS + 1;

    // memory access decided for one request
    typedef struct packed {
        logic rd;   // replay: read the ring
        logic wr;   // record: append sample to the ring
        logic hit;  // read entry was written since reset
    } ast_access_t;

endpackage

`default_nettype wire

>>> hw/rtl/ast_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ast_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ast_ctrl.sv
// segment and repeat counters, ring pointer and fill tracking
`timescale 1ns / 1ps
`default_nettype none

module ast_ctrl #(
    parameter int STORE_DEPTH = ast_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               advance,
    input  wire logic                               trigger,
    input  wire logic [ast_pkg::LEN_BITS-1:0]       stutter_length,
    input  wire logic [ast_pkg::COUNT_BITS-1:0]     repeat_count,
    output ast_pkg::ast_access_t                    acc,
    output logic      [$clog2(STORE_DEPTH)-1:0]     addr
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int CW = (LW > ast_pkg::LEN_BITS) ? LW : ast_pkg::LEN_BITS;
    localparam int PW = LW + 1;

    logic [AW-1:0]                  wp_reg, wp_next;
    logic                           wrapped_reg, wrapped_next;
    logic [ast_pkg::INDEX_BITS-1:0] index_reg, index_next;
    logic [ast_pkg::COUNT_BITS-1:0] pending_reg, pending_next;
    logic [LW-1:0]                  left_reg, left_next;

    logic [CW-1:0]                  raw_ext;
    logic [LW-1:0]                  len;
    logic [PW-1:0]                  wp_ext;
    logic [PW-1:0]                  back_ext;
    logic [AW-1:0]                  pos;

    // effective segment length: zero taken as one, clamped to depth
    always_comb
    begin
        raw_ext = CW'(stutter_length);
        if (raw_ext == '0)
        begin
            len = LW'(1);
        end
        else if (raw_ext > CW'(STORE_DEPTH))
        begin
            len = LW'(STORE_DEPTH);
        end
        else
        begin
            len = LW'(raw_ext);
        end
    end

    always_comb
    begin
        index_next   = trigger ? '0 : index_reg;
        pending_next = trigger ? repeat_count : pending_reg;
        left_next    = trigger ? len : left_reg;

        if (pending_next != '0)
        begin
            if (left_next != '0)
            begin
                left_next = left_next - LW'(1);
            end
            if (left_next == '0)
            begin
                index_next = index_next + ast_pkg::INDEX_BITS'(1);
                if (index_next > ast_pkg::INDEX_BITS'(pending_next))
                begin
                    pending_next = '0;
                    index_next   = '0;
                end
                else
                begin
                    left_next = len;
                end
            end
        end

        // replay offset back from the write pointer, modulo depth
        wp_ext   = PW'(wp_reg);
        back_ext = PW'(left_next);
        if (wp_ext >= back_ext)
        begin
            pos = AW'(wp_ext - back_ext);
        end
        else
        begin
            pos = AW'(wp_ext + PW'(STORE_DEPTH) - back_ext);
        end

        acc.rd  = (index_next != '0);
        acc.wr  = (index_next == '0);
        acc.hit = wrapped_reg || (pos < wp_reg);
        addr    = acc.rd ? pos : wp_reg;

        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (acc.wr)
        begin
            if (wp_reg == AW'(STORE_DEPTH - 1))
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            index_reg   <= '0;
            pending_reg <= '0;
            left_reg    <= '0;
        end
        else if (advance)
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            index_reg   <= index_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/audio_stutter_repeat.sv
// top level of the single-channel audio stutter repeat effect
`timescale 1ns / 1ps
`default_nettype none

// Single-channel stutter effect: one sample request in, one sample out.
// A trigger records the current segment into a ring memory while passing
// it through, then replays that segment repeat_count times before going
// back to pass-through. Throughput is one request per cycle while
// sample_stall is low. An accepted request updates the counters and
// either writes the sample into the single-port ring memory or reads a
// past sample from it, the memory stage then holds the registered memory
// data, and the result sits in an output register. Each request only
// reads or only writes the ring, so one memory port is enough. The ring
// needs no clearing pass after reset: since it fills in order from slot
// zero, a wrap flag and the write pointer tell which slots hold data, and
// unwritten slots read as zero. Use one instance per audio channel.
module audio_stutter_repeat #(
    parameter int STORE_DEPTH = ast_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = ast_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // sample request channel
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
    input  wire logic                           trigger,
    input  wire logic [ast_pkg::LEN_BITS-1:0]   stutter_length,
    input  wire logic [ast_pkg::COUNT_BITS-1:0] repeat_count,
    // result request channel
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic signed [SAMPLE_BITS-1:0]       out_sample
);

    localparam int AW = $clog2(STORE_DEPTH);

    ast_pkg::ast_access_t   acc;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   accept;
    logic                   out_free;

    // memory stage: request whose ring access has been issued
    logic                   s1_valid_reg;
    logic                   s1_rd_reg;
    logic                   s1_hit_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    // output stage
    logic                   result_valid_reg;
    logic [SAMPLE_BITS-1:0] result_sample_reg;
    logic [SAMPLE_BITS-1:0] result_sample_next;

    // output register can take a new result when empty or being drained
    assign out_free     = !result_valid_reg || !result_stall;
    // hold off only when the memory stage is full and cannot move on
    assign sample_stall = s1_valid_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    ast_ctrl #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .trigger        (trigger),
        .stutter_length (stutter_length),
        .repeat_count   (repeat_count),
        .acc            (acc),
        .addr           (ram_addr)
    );

    // ring memory; read data only changes on a new read, so it holds
    // while the memory stage is stalled
    ast_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .en    (accept),
        .we    (acc.wr),
        .addr  (ram_addr),
        .wdata (sample_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg     <= acc.rd;
            s1_hit_reg    <= acc.hit;
            s1_sample_reg <= sample_in;
        end
    end

    // replayed sample from the ring, zero for a slot never written,
    // otherwise straight pass-through
    always_comb
    begin
        if (s1_rd_reg)
        begin
            result_sample_next = s1_hit_reg ? ram_rdata : '0;
        end
        else
        begin
            result_sample_next = s1_sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            result_sample_reg <= result_sample_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_sample   = result_sample_reg;

`ifndef SYNTHESIS
    // a request in the memory stage is never dropped while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("memory stage request lost under stall");

    // stalling the input only happens with a full memory stage
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && result_valid_reg)
        else $error("input stalled without a full pipeline");

    // every accepted request does exactly one ring access kind
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (acc.rd != acc.wr))
        else $error("ring read and write in the same request");

    // an accepted request shows up in the memory stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request missing from memory stage");
`endif

endmodule

`default_nettype wire

>>> tb/tb_audio_stutter_repeat.sv
// self-checking testbench for the single-channel audio stutter repeat block
`timescale 1ns / 1ps

module tb_audio_stutter_repeat;

    localparam int LEN_W      = ast_pkg::LEN_BITS;
    localparam int CNT_W      = ast_pkg::COUNT_BITS;
    localparam int RING_DEPTH = ast_pkg::STORE_DEPTH_DEF;
    localparam int SMP_W      = ast_pkg::SAMPLE_BITS_DEF;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int MAX_LEN    = (1 << LEN_W) - 1;
    localparam int MAX_COUNT  = (1 << CNT_W) - 1;

    // one sample request as offered to the block
    typedef struct {
        logic signed [SMP_W-1:0]    smp;
        logic                       trig;
        logic [LEN_W-1:0]           len;
        logic [CNT_W-1:0]           cnt;
    } stutter_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           sample_valid   = 1'b0;
    logic                           sample_stall;
    logic signed [SMP_W-1:0]        sample_in      = '0;
    logic                           trigger        = 1'b0;
    logic [LEN_W-1:0]               stutter_length = '0;
    logic [CNT_W-1:0]               repeat_count   = '0;
    logic                           result_valid;
    logic                           result_stall   = 1'b0;
    logic signed [SMP_W-1:0]        out_sample;

    // pending requests, and output samples still owed by the block
    stutter_req_t               req_q[$];
    logic signed [SMP_W-1:0]    owed_samples[$];

    // shadow of the block's ring and counters
    logic [SMP_W-1:0]           ring_mem [0:RING_DEPTH-1];
    logic [PTR_W-1:0]           wr_ptr;
    int unsigned                rep_idx;
    int unsigned                reps_left;
    int unsigned                seg_left;

    int     req_accepted   = 0;
    int     trig_accepted  = 0;
    int     replay_cnt     = 0;
    int     in_stall_cycles = 0;
    int     results_seen   = 0;
    int     err_cnt        = 0;
    int     send_gap       = 0;
    int     send_quiet     = 0;
    int     stall_left     = 0;
    int     recv_quiet     = 0;
    logic   hold_off       = 1'b0;
    stutter_req_t nxt_req;

    audio_stutter_repeat DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample_in      (sample_in),
        .trigger        (trigger),
        .stutter_length (stutter_length),
        .repeat_count   (repeat_count),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_sample     (out_sample)
    );

    always #4 clk = ~clk;

    // expected output sample for one accepted request; advances the shadow state
    function automatic logic signed [SMP_W-1:0] stutter_predict(input stutter_req_t r);
        int unsigned        seg_len;
        logic [PTR_W-1:0]   rd_ptr;
        logic [SMP_W-1:0]   res;
        // zero length means one sample, long lengths clamp to the ring size
        if (r.len == 0)
            seg_len = 1;
        else if (r.len > RING_DEPTH)
            seg_len = RING_DEPTH;
        else
            seg_len = int'(r.len);
        res = r.smp;
        // a trigger restarts the stutter from this sample
        if (r.trig)
        begin
            rep_idx   = 0;
            reps_left = int'(r.cnt);
            seg_left  = seg_len;
        end
        if (reps_left > 0)
        begin
            // counter stays at zero rather than wrapping
            if (seg_left > 0)
                seg_left--;
            if (seg_left == 0)
            begin
                rep_idx++;
                if (rep_idx > reps_left)
                begin
                    reps_left = 0;
                    rep_idx   = 0;
                end
                else
                    seg_left = seg_len;
            end
            // replay: offset equal to the ring size lands on the oldest entry
            if (rep_idx != 0)
            begin
                rd_ptr = wr_ptr - PTR_W'(seg_left);
                res    = ring_mem[rd_ptr];
                replay_cnt++;
            end
        end
        // record only while passing through
        if (rep_idx == 0)
        begin
            ring_mem[wr_ptr] = r.smp;
            wr_ptr           = wr_ptr + PTR_W'(1);
        end
        return res;
    endfunction

    // idle length for either side: mostly none or short, a few long, some quiet stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if (r < 6)
        begin
            quiet = $urandom_range(20, 150);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(SMP_W-1){1'b1}}};
            1:       return {1'b1, {(SMP_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic push_req(input logic signed [SMP_W-1:0] s, input logic t,
                            input int l, input int c);
        stutter_req_t r;
        r.smp  = s;
        r.trig = t;
        r.len  = LEN_W'(l);
        r.cnt  = CNT_W'(c);
        req_q.insert(req_q.size(), r);
    endtask

    // mostly well-formed stutters with random content, plus noise and cut-short ones
    task automatic add_random(input int target);
        int made;
        int seg_len;
        int reps;
        int span;
        int k;
        int r;
        made = 0;
        while (made < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                r = $urandom_range(0, 99);
                seg_len = (r < 10) ? 0 :
                          (r < 80) ? $urandom_range(1, 32) : $urandom_range(33, 300);
                r = $urandom_range(0, 99);
                if (r < 10)
                    reps = 0;
                else if (r < 85)
                    reps = $urandom_range(1, 6);
                else if (r < 95)
                begin
                    reps = $urandom_range(7, 40);
                    if (seg_len > 8)
                        seg_len = $urandom_range(1, 8);
                end
                else
                begin
                    reps    = $urandom_range(200, MAX_COUNT);
                    seg_len = $urandom_range(1, 2);
                end
                span = ((seg_len == 0) ? 1 : seg_len) * (reps + 1);
                // broken sequence: cut off early, often by the next trigger
                if ($urandom_range(0, 99) < 15)
                    span = $urandom_range(1, span);
                push_req(rand_sample(), 1'b1, seg_len, reps);
                for (k = 1; k < span; k++)
                    push_req(rand_sample(), 1'b0,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN) : seg_len,
                             $urandom_range(0, MAX_COUNT));
                made += span;
                k = $urandom_range(0, 4);
                repeat (k)
                    push_req(rand_sample(), 1'b0, $urandom_range(0, MAX_LEN),
                             $urandom_range(0, MAX_COUNT));
                made += k;
            end
            else
            begin
                k = $urandom_range(1, 10);
                repeat (k)
                begin
                    r = ($urandom_range(0, 3) == 0);
                    push_req(rand_sample(), r[0], $urandom_range(0, MAX_LEN),
                             r ? $urandom_range(0, 3) : $urandom_range(0, MAX_COUNT));
                end
                made += k;
            end
        end
    endtask

    // sender: offers the next request once the previous one has gone, after any random idle gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                nxt_req.smp  = sample_in;
                nxt_req.trig = trigger;
                nxt_req.len  = stutter_length;
                nxt_req.cnt  = repeat_count;
                owed_samples.insert(owed_samples.size(), stutter_predict(nxt_req));
                req_accepted++;
                if (trigger)
                    trig_accepted++;
            end
            if (sample_valid && sample_stall)
                in_stall_cycles++;
            // payload only moves once the current request is taken
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    nxt_req = req_q.pop_front();
                    sample_in      <= nxt_req.smp;
                    trigger        <= nxt_req.trig;
                    stutter_length <= nxt_req.len;
                    repeat_count   <= nxt_req.cnt;
                    sample_valid   <= 1'b1;
                    send_gap = pick_gap(send_quiet);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each taken result against the oldest owed sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_samples.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing owed, out_sample=%0d", $realtime,
                                 out_sample);
                end
                else
                begin
                    results_seen++;
                    if (out_sample !== owed_samples[0])
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: out_sample mismatch on result %0d: %s %0d, got %0d",
                                     $realtime, results_seen, "expected", owed_samples[0],
                                     out_sample);
                    end
                    void'(owed_samples.pop_front());
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(recv_quiet);
            result_stall <= hold_off || (stall_left > 0);
        end
    end

    // long receiver hold-off so the block fills up and pushes back on its input
    initial
    begin
        while (req_accepted < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main_seq
        int k;
        for (k = 0; k < RING_DEPTH; k++)
            ring_mem[k] = '0;
        wr_ptr    = '0;
        rep_idx   = 0;
        reps_left = 0;
        seg_left  = 0;

        // short segment, then a longer reload reaching slots never written
        push_req(16'sh1234, 1'b1, 2, 1);
        push_req(rand_sample(), 1'b0, 100, 0);
        push_req({1'b1, {(SMP_W-1){1'b0}}}, 1'b0, 100, 0);
        push_req(rand_sample(), 1'b0, 100, 0);
        // retrigger with zero repeats drops back to pass-through
        push_req(rand_sample(), 1'b1, 0, 0);
        push_req({1'b0, {(SMP_W-1){1'b1}}}, 1'b0, 0, 0);
        push_req({1'b1, {(SMP_W-1){1'b0}}}, 1'b0, MAX_LEN, MAX_COUNT);
        // zero length taken as one, two repeats
        push_req(rand_sample(), 1'b1, 0, 2);
        repeat (3) push_req(rand_sample(), 1'b0, 0, 0);
        // retrigger in the middle of a replay, with a clamped length
        push_req(rand_sample(), 1'b1, 3, 2);
        repeat (5) push_req(rand_sample(), 1'b0, 3, 0);
        push_req(rand_sample(), 1'b1, MAX_LEN, 0);
        // most repeats on a one-sample segment, cut short by a retrigger
        push_req(rand_sample(), 1'b1, 1, MAX_COUNT);
        repeat (4) push_req(rand_sample(), 1'b0, 1, 0);
        push_req(rand_sample(), 1'b1, RING_DEPTH, 0);
        push_req(rand_sample(), 1'b0, 1, 0);

        add_random(600);
        // reload to a clamped length: replay offsets counting down from the ring size
        push_req(rand_sample(), 1'b1, 2, 1);
        for (k = 0; k < 40; k++)
            push_req(rand_sample(), 1'b0, $urandom_range(RING_DEPTH, MAX_LEN), 0);
        push_req(rand_sample(), 1'b1, 0, 0);
        repeat (8) push_req(rand_sample(), 1'b0, 1, 0);
        add_random(600);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || sample_valid)
            @(posedge clk);
        while (owed_samples.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d requests with %0d triggers; %0d results checked, %0d replayed",
                 req_accepted, trig_accepted, results_seen, replay_cnt);
        $display("input was held off for %0d cycles by back-pressure", in_stall_cycles);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ast_pkg.sv
hw/rtl/ast_ram.sv
hw/rtl/ast_ctrl.sv
hw/rtl/audio_stutter_repeat.sv
tb/tb_audio_stutter_repeat.sv
